@@ hw/rtl/i2p_pkg.sv @@
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  // ASCII characters the converter recognizes or produces.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;
  localparam logic [7:0] CH_LC_LO  = 8'h61;
  localparam logic [7:0] CH_LC_HI  = 8'h7A;

  // Operator codes held on the stack.
  localparam logic [2:0] OP_LPAREN = 3'd0;
  localparam logic [2:0] OP_PLUS   = 3'd1;
  localparam logic [2:0] OP_MINUS  = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMATCHED = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef enum logic [2:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_OTHER
  } char_class_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_SP2,
    S_ERR,
    S_END_SP,
    S_FLUSH
  } state_t;

  // One result handed from the control logic to the output stage.
  // finish marks the result already held as the last one of its item.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       finish;
    logic [7:0] ch;
    logic       done;
    logic [1:0] status;
  } emit_t;

  function automatic char_class_t classify(logic [7:0] c);
    char_class_t k;
    if ((c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_UC_LO && c <= CH_UC_HI) ||
        (c >= CH_LC_LO && c <= CH_LC_HI)) begin
      k = CLS_ALNUM;
    end else if (c == CH_LPAREN) begin
      k = CLS_OPEN;
    end else if (c == CH_RPAREN) begin
      k = CLS_CLOSE;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      k = CLS_OP;
    end else begin
      k = CLS_OTHER;
    end
    return k;
  endfunction

  function automatic logic [2:0] op_code_of(logic [7:0] c);
    logic [2:0] code;
    case (c)
      CH_PLUS:  code = OP_PLUS;
      CH_MINUS: code = OP_MINUS;
      CH_STAR:  code = OP_MUL;
      CH_SLASH: code = OP_DIV;
      default:  code = OP_LPAREN;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] op_char(logic [2:0] code);
    logic [7:0] c;
    case (code)
      OP_PLUS:  c = CH_PLUS;
      OP_MINUS: c = CH_MINUS;
      OP_MUL:   c = CH_STAR;
      OP_DIV:   c = CH_SLASH;
      default:  c = CH_LPAREN;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] prio(logic [2:0] code);
    logic [1:0] p;
    case (code)
      OP_PLUS, OP_MINUS: p = 2'd1;
      OP_MUL, OP_DIV:    p = 2'd2;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/i2p_out_stage.sv @@
module i2p_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  i2p_pkg::emit_t    emit,
  output logic              can_emit,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        char_out,
  output logic              run_last,
  output logic              expr_done,
  output logic [1:0]        status
);

  // A result is held back one step in the pending register so that its
  // run_last bit can be set once the control logic knows whether more
  // results of the same item follow.
  logic       pend_v;
  logic       pend_last;
  logic [7:0] pend_ch;
  logic       pend_done;
  logic [1:0] pend_status;
  logic       out_free;
  logic       move;

  assign out_free = !out_valid || !out_stall;
  assign can_emit = !pend_v || out_free;
  assign move     = pend_v && out_free && (pend_last || emit.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (emit.valid) begin
        pend_v <= 1'b1;
      end else if (move) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      char_out  <= pend_ch;
      run_last  <= pend_last;
      expr_done <= pend_done;
      status    <= pend_status;
    end
    if (emit.valid) begin
      pend_ch     <= emit.ch;
      pend_last   <= emit.last;
      pend_done   <= emit.done;
      pend_status <= emit.status;
    end else if (emit.finish) begin
      pend_last <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/infix_to_postfix_converter_unit.sv @@
// Infix to postfix converter (shunting-yard).
// Input channel: one ASCII character per item on char_in, with expr_end set
// on the final character of an expression. Output channel: one postfix
// character per item on char_out, with run_last on the last result caused
// by an input item, expr_done on the final result of the expression and
// status reporting an unmatched ')' or an operator stack overflow.
// The operator stack sits in a synchronous RAM with a registered read.
// Letters, digits, '(' and ignored characters are handled as they are accepted.
// An operator or ')' emits a separator and then pops entries one at a time,
// each pop followed by a read of the new top; after each operator pop a
// separator follows as well. The end-of-expression flush emits a separator
// and then pops every stacked entry, each pop followed by a RAM read.
// A result reaches char_out through a pending register, where it waits
// until its run_last bit is known.
// When the receiver stalls, production of results pauses and input is
// stalled; nothing is lost. Reset clears the stack count, the error state
// and both valid flags; the RAM contents are left as they are, since data
// read from entries at or above the stack count is never used.
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       expr_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       run_last,
  output logic       expr_done,
  output logic [1:0] status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  i2p_pkg::state_t      state, state_next;
  logic [CW-1:0]        count, count_next;
  logic                 err_hold, err_hold_next;
  logic [1:0]           err_code, err_code_next;
  i2p_pkg::char_class_t kind, kind_next;
  logic                 end_r, end_next;
  logic [2:0]           code_r, code_next;

  logic [2:0]           mem [STACK_DEPTH];
  logic [2:0]           rd_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [2:0]           wr_data;

  i2p_pkg::emit_t       emit;
  logic                 can_emit;
  logic                 accept;
  i2p_pkg::char_class_t in_kind;
  logic [CW-1:0]        count_m1;
  logic [CW-1:0]        count_m2;
  logic                 full;
  logic                 empty;

  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);
  assign full     = (count == CW'(STACK_DEPTH));
  assign empty    = (count == '0);
  assign in_kind  = i2p_pkg::classify(char_in);
  assign in_stall = (state != i2p_pkg::S_IDLE) || !can_emit;
  assign accept   = in_valid && !in_stall;

  // Every push either ends the item or hands over to the flush, so the next
  // read is issued at a later edge than the write and never meets it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= i2p_pkg::S_IDLE;
      count    <= '0;
      err_hold <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      err_hold <= err_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    err_code <= err_code_next;
    kind     <= kind_next;
    end_r    <= end_next;
    code_r   <= code_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    err_hold_next = err_hold;
    err_code_next = err_code;
    kind_next     = kind;
    end_next      = end_r;
    code_next     = code_r;
    rd_en         = 1'b0;
    rd_addr       = count_m1[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = count[AW-1:0];
    wr_data       = code_r;
    emit          = '0;
    emit.status   = i2p_pkg::ST_OK;

    case (state)
      i2p_pkg::S_IDLE: begin
        if (accept) begin
          kind_next = in_kind;
          end_next  = expr_end;
          code_next = i2p_pkg::op_code_of(char_in);
          if (err_hold) begin
            if (expr_end) begin
              err_hold_next = 1'b0;
            end
          end else begin
            case (in_kind)
              i2p_pkg::CLS_ALNUM: begin
                emit.valid = 1'b1;
                emit.ch    = char_in;
                emit.last  = !expr_end;
                if (expr_end) begin
                  state_next = i2p_pkg::S_END_SP;
                end
              end
              i2p_pkg::CLS_OPEN: begin
                if (full) begin
                  err_code_next = i2p_pkg::ST_OVERFLOW;
                  state_next    = i2p_pkg::S_ERR;
                end else begin
                  wr_en      = 1'b1;
                  wr_data    = i2p_pkg::OP_LPAREN;
                  count_next = count + CW'(1);
                  if (expr_end) begin
                    state_next = i2p_pkg::S_END_SP;
                  end
                end
              end
              i2p_pkg::CLS_CLOSE, i2p_pkg::CLS_OP: begin
                emit.valid = 1'b1;
                emit.ch    = i2p_pkg::CH_SPACE;
                rd_en      = 1'b1;
                state_next = i2p_pkg::S_CHK;
              end
              default: begin
                if (expr_end) begin
                  state_next = i2p_pkg::S_END_SP;
                end
              end
            endcase
          end
        end
      end

      i2p_pkg::S_CHK: begin
        // rd_data holds the current top of the stack here.
        if (kind == i2p_pkg::CLS_CLOSE) begin
          if (empty) begin
            err_code_next = i2p_pkg::ST_UNMATCHED;
            state_next    = i2p_pkg::S_ERR;
          end else if (rd_data != i2p_pkg::OP_LPAREN) begin
            if (can_emit) begin
              emit.valid = 1'b1;
              emit.ch    = i2p_pkg::op_char(rd_data);
              count_next = count_m1;
              rd_en      = 1'b1;
              rd_addr    = count_m2[AW-1:0];
            end
          end else begin
            count_next = count_m1;
            if (end_r) begin
              state_next = i2p_pkg::S_END_SP;
            end else begin
              emit.finish = 1'b1;
              state_next  = i2p_pkg::S_IDLE;
            end
          end
        end else begin
          if (!empty && (i2p_pkg::prio(rd_data) >= i2p_pkg::prio(code_r))) begin
            if (can_emit) begin
              emit.valid = 1'b1;
              emit.ch    = i2p_pkg::op_char(rd_data);
              count_next = count_m1;
              rd_en      = 1'b1;
              rd_addr    = count_m2[AW-1:0];
              state_next = i2p_pkg::S_SP2;
            end
          end else if (full) begin
            err_code_next = i2p_pkg::ST_OVERFLOW;
            state_next    = i2p_pkg::S_ERR;
          end else begin
            wr_en      = 1'b1;
            wr_data    = code_r;
            count_next = count + CW'(1);
            if (end_r) begin
              state_next = i2p_pkg::S_END_SP;
            end else begin
              emit.finish = 1'b1;
              state_next  = i2p_pkg::S_IDLE;
            end
          end
        end
      end

      i2p_pkg::S_SP2: begin
        if (can_emit) begin
          emit.valid = 1'b1;
          emit.ch    = i2p_pkg::CH_SPACE;
          state_next = i2p_pkg::S_CHK;
        end
      end

      i2p_pkg::S_ERR: begin
        if (can_emit) begin
          emit.valid    = 1'b1;
          emit.ch       = i2p_pkg::CH_NUL;
          emit.done     = 1'b1;
          emit.status   = err_code;
          emit.last     = 1'b1;
          count_next    = '0;
          err_hold_next = !end_r;
          state_next    = i2p_pkg::S_IDLE;
        end
      end

      i2p_pkg::S_END_SP: begin
        if (can_emit) begin
          emit.valid = 1'b1;
          emit.ch    = i2p_pkg::CH_SPACE;
          emit.done  = empty;
          emit.last  = empty;
          if (empty) begin
            state_next = i2p_pkg::S_IDLE;
          end else begin
            rd_en      = 1'b1;
            state_next = i2p_pkg::S_FLUSH;
          end
        end
      end

      i2p_pkg::S_FLUSH: begin
        if (can_emit) begin
          emit.valid = 1'b1;
          emit.ch    = i2p_pkg::op_char(rd_data);
          emit.done  = (count == CW'(1));
          emit.last  = (count == CW'(1));
          count_next = count_m1;
          rd_en      = 1'b1;
          rd_addr    = count_m2[AW-1:0];
          if (count == CW'(1)) begin
            state_next = i2p_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = i2p_pkg::S_IDLE;
      end
    endcase
  end

  i2p_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .can_emit  (can_emit),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .char_out  (char_out),
    .run_last  (run_last),
    .expr_done (expr_done),
    .status    (status)
  );

endmodule

@@ hw/rtl/i2p_checker.sv @@
module i2p_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] char_out,
  input logic       run_last,
  input logic       expr_done,
  input logic [1:0] status
);

  // The output channel comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(char_out) && $stable(run_last) &&
      $stable(expr_done) && $stable(status))
    else $error("stalled result changed");

  // The final result of an expression always closes its input item.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && expr_done |-> run_last)
    else $error("expr_done without run_last");

  // An error result ends the expression and carries no character.
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != i2p_pkg::ST_OK) |->
      expr_done && (char_out == i2p_pkg::CH_NUL))
    else $error("malformed error result");

endmodule

bind infix_to_postfix_converter_unit i2p_checker u_i2p_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .char_out  (char_out),
  .run_last  (run_last),
  .expr_done (expr_done),
  .status    (status)
);
